[hw/rtl/three_button_gesture_classifier_top_macros.svh]
// Assertion macros for the top RTL file of the gesture classifier.
// Each macro takes a label, a property expression and a message.
`ifndef THREE_BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define THREE_BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define TBGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression never holds at a clock edge outside reset.
`define TBGC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define TBGC_ASSERT(lbl, prop, msg)
`define TBGC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[hw/rtl/tbgc_pkg.sv]
`default_nettype none

package tbgc_pkg;

	// Field and register widths.
	localparam int CFG_W     = 12;
	localparam int TALLY_W   = 8;
	localparam int BTN_W     = 2;
	localparam int KIND_W    = 3;
	localparam int NUM_LANES = 3;
	localparam int NUM_SLOTS = 6;
	localparam int SLOT_W    = 3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LONG_HOLD  = 2'd0;
	localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
	localparam logic [1:0] REG_WINDOW     = 2'd2;

	// Register values after reset.
	localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 12'd200;
	localparam logic [CFG_W-1:0] SHORT_HOLD_RST = 12'd120;
	localparam logic [CFG_W-1:0] WINDOW_RST     = 12'd120;

	// Event kinds.
	localparam logic [KIND_W-1:0] KIND_SINGLE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LONG_START = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LONG_CONT  = 3'd4;

	// What a lane is told to do for one item.
	typedef struct packed {
		logic pushed;
		logic hold_en;
		logic clear_en;
		logic release_en;
		logic win_fire;
	} lane_ctl_t;

	// What a lane found for one item: a poll event and a window event.
	typedef struct packed {
		logic              poll_vld;
		logic [KIND_W-1:0] poll_kind;
		logic              win_vld;
		logic [KIND_W-1:0] win_kind;
	} lane_evt_t;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BTN_W-1:0]  button;
	} evt_t;

endpackage

`default_nettype wire

[hw/rtl/tbgc_lane.sv]
`default_nettype none

// One button: hold counter, press tally and long-press flag.
module tbgc_lane
	import tbgc_pkg::*;
#(
	parameter int COUNT_BITS = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire lane_ctl_t        ctl,
	input  wire logic [CFG_W-1:0] long_hold,
	input  wire logic [CFG_W-1:0] short_hold,
	output lane_evt_t             evt
);

	localparam int CMP_W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;

	logic [COUNT_BITS-1:0] hold_q;
	logic [TALLY_W-1:0]    tally_q;
	logic                  long_q;

	logic [COUNT_BITS-1:0] hold_inc;
	logic [COUNT_BITS-1:0] hold_d;
	logic [TALLY_W-1:0]    tally_a;
	logic [TALLY_W-1:0]    tally_b;
	logic [TALLY_W-1:0]    tally_d;
	logic                  long_d;
	logic [CMP_W-1:0]      inc_x;
	logic [CMP_W-1:0]      long_x;
	logic [CMP_W-1:0]      short_x;
	logic [CMP_W-1:0]      hold_plus;

	always_comb begin
		long_x  = CMP_W'(long_hold);
		short_x = CMP_W'(short_hold);

		// Push adds to the tally, saturating.
		tally_a = tally_q;
		if (ctl.pushed && (tally_q != {TALLY_W{1'b1}})) begin
			tally_a = tally_q + TALLY_W'(1);
		end

		hold_inc = (hold_q == {COUNT_BITS{1'b1}}) ? hold_q : hold_q + COUNT_BITS'(1);
		inc_x    = CMP_W'(hold_inc);

		evt     = '0;
		hold_d  = hold_q;
		long_d  = long_q;
		tally_b = tally_a;

		// Poll: count up while held, fire a long event at the period.
		if (ctl.hold_en) begin
			hold_d = hold_inc;
			if (inc_x >= long_x) begin
				hold_d        = COUNT_BITS'(inc_x - long_x);
				evt.poll_vld  = 1'b1;
				evt.poll_kind = long_q ? KIND_LONG_CONT : KIND_LONG_START;
				long_d        = 1'b1;
				tally_b       = '0;
			end
		end else if (ctl.clear_en) begin
			hold_d = '0;
		end

		// Release: end a long press, or report a late single.
		if (ctl.release_en) begin
			if (long_q) begin
				long_d = 1'b0;
			end else if (CMP_W'(hold_q) >= short_x) begin
				evt.poll_vld  = 1'b1;
				evt.poll_kind = KIND_SINGLE;
			end
		end

		// Window expiry reports one to three presses.
		tally_d   = tally_b;
		hold_plus = CMP_W'(hold_d) + CMP_W'(1);
		if (ctl.win_fire && !long_d && (hold_plus < short_x)) begin
			if ((tally_b != '0) && (tally_b <= TALLY_W'(3))) begin
				evt.win_vld  = 1'b1;
				evt.win_kind = KIND_W'(tally_b - TALLY_W'(1));
			end
			tally_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			tally_q <= '0;
			long_q  <= 1'b0;
		end else if (en) begin
			hold_q  <= hold_d;
			tally_q <= tally_d;
			long_q  <= long_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tbgc_merge.sv]
`default_nettype none

// Puts the lane events into result order: poll events first, then window events.
module tbgc_merge
	import tbgc_pkg::*;
(
	input  wire lane_evt_t       lane_evt [NUM_LANES],
	input  wire logic            release_order,
	output evt_t                 slot [NUM_SLOTS],
	output logic [NUM_SLOTS-1:0] slot_vld
);

	logic [BTN_W-1:0] poll_btn [NUM_LANES];

	always_comb begin
		// A release reports button two before button one.
		if (release_order) begin
			poll_btn[0] = BTN_W'(1);
			poll_btn[1] = BTN_W'(0);
		end else begin
			poll_btn[0] = BTN_W'(0);
			poll_btn[1] = BTN_W'(1);
		end
		poll_btn[2] = BTN_W'(2);

		for (int i = 0; i < NUM_LANES; i++) begin
			slot[i].button            = poll_btn[i];
			slot[i].kind              = lane_evt[poll_btn[i]].poll_kind;
			slot_vld[i]               = lane_evt[poll_btn[i]].poll_vld;
			slot[NUM_LANES+i].button  = BTN_W'(i);
			slot[NUM_LANES+i].kind    = lane_evt[i].win_kind;
			slot_vld[NUM_LANES+i]     = lane_evt[i].win_vld;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tbgc_evq.sv]
`default_nettype none

// Holds one item's results; hands them out one per cycle while m_tready is high.
module tbgc_evq
	import tbgc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire evt_t                 slot [NUM_SLOTS],
	input  wire logic [NUM_SLOTS-1:0] slot_vld,
	output logic                      room,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,  // [1:0] event_button, [4:2] event_kind
	output logic                      m_tlast   // last_event
);

	evt_t                 slot_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;
	logic [SLOT_W-1:0]    head;
	logic [NUM_SLOTS-1:0] head_bit;
	logic                 take;

	// Lowest pending slot goes out first.
	always_comb begin
		head = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (vld_q[i]) begin
				head = SLOT_W'(i);
			end
		end
		head_bit = NUM_SLOTS'(1) << head;
	end

	assign m_tvalid = |vld_q;
	assign m_tdata  = 8'(slot_q[head]);
	assign m_tlast  = ((vld_q & ~head_bit) == '0);
	assign take     = m_tvalid && m_tready;
	assign room     = !m_tvalid || (take && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (load) begin
			vld_q <= slot_vld;
		end else if (take) begin
			vld_q <= vld_q & ~head_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= slot;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/three_button_gesture_classifier_top.sv]
// Three-button gesture classifier. Feed one input item per poll tick on the s_
// stream; it carries the three button levels and any debounced push edge. The
// block answers with zero to six events on the m_ stream (single, double,
// triple, long start, long continue), the final one of each tick marked by
// m_tlast. An input item is registered into three button lanes that work on
// it side by side; its events then leave through the single output port, one
// per cycle while m_tready is high, and the next input item is taken in the
// cycle its last event goes out. The three registers are written through the
// cfg_ port (always ready); the user must write them only while the block is
// idle (not enforced by the block); there is no start-up pass after reset.
`default_nettype none

`include "three_button_gesture_classifier_top_macros.svh"

module three_button_gesture_classifier_top
	import tbgc_pkg::*;
#(
	parameter int COUNT_BITS = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,  // [0] held_one, [1] held_two, [2] held_three,
	                                        // [4:3] push_button
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,  // [1:0] event_button, [4:2] event_kind
	output logic                  m_tlast,  // last_event
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] long_hold_q;
	logic [CFG_W-1:0] short_hold_q;
	logic [CFG_W-1:0] window_q;
	logic [CFG_W-1:0] window_remaining_q;
	logic             window_armed_q;
	logic             poll_running_q;

	logic             accept;
	logic [2:0]       held;
	logic [1:0]       push;
	logic             pushed_any;
	logic             poll_a;
	logic             armed_a;
	logic [CFG_W-1:0] remain_a;
	logic             win_fire;
	logic             none_held;
	logic             room;

	lane_ctl_t            lane_ctl [NUM_LANES];
	lane_evt_t            lane_evt [NUM_LANES];
	evt_t                 slot     [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_vld;

	assign cfg_ready = 1'b1;
	assign s_tready  = room;
	assign accept    = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_q  <= LONG_HOLD_RST;
			short_hold_q <= SHORT_HOLD_RST;
			window_q     <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LONG_HOLD:  long_hold_q  <= cfg_data;
				REG_SHORT_HOLD: short_hold_q <= cfg_data;
				REG_WINDOW:     window_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Push, poll enable and window timing shared by all lanes.
	always_comb begin
		held       = s_tdata[2:0];
		push       = s_tdata[4:3];
		pushed_any = (push != 2'd0);
		poll_a     = poll_running_q || pushed_any;
		armed_a    = window_armed_q || pushed_any;
		remain_a   = pushed_any ? window_q : window_remaining_q;
		win_fire   = armed_a && (remain_a == '0);
		none_held  = (held == 3'b000);

		for (int i = 0; i < NUM_LANES; i++) begin
			lane_ctl[i].pushed     = pushed_any && (push == 2'(i + 1));
			lane_ctl[i].release_en = poll_a && none_held;
			lane_ctl[i].win_fire   = win_fire;
		end
		// Buttons one and two may count together; button three only alone.
		lane_ctl[0].hold_en = poll_a && held[0];
		lane_ctl[1].hold_en = poll_a && held[1];
		lane_ctl[2].hold_en = poll_a && held[2] && !held[0] && !held[1];
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_ctl[i].clear_en = poll_a && !lane_ctl[i].hold_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_remaining_q <= '0;
			window_armed_q     <= 1'b0;
			poll_running_q     <= 1'b0;
		end else if (accept) begin
			poll_running_q     <= poll_a;
			window_armed_q     <= armed_a && !win_fire;
			window_remaining_q <= (armed_a && !win_fire) ? remain_a - CFG_W'(1) : remain_a;
		end
	end

	// One lane per button.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		tbgc_lane #(
			.COUNT_BITS(COUNT_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.ctl        (lane_ctl[g]),
			.long_hold  (long_hold_q),
			.short_hold (short_hold_q),
			.evt        (lane_evt[g])
		);
	end

	tbgc_merge u_merge (
		.lane_evt      (lane_evt),
		.release_order (none_held),
		.slot          (slot),
		.slot_vld      (slot_vld)
	);

	tbgc_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.slot     (slot),
		.slot_vld (slot_vld),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A new item only comes in once the previous item's events are all out.
	`TBGC_ASSERT(a_accept_when_drained, accept |-> (!m_tvalid || (m_tready && m_tlast)), "item accepted over pending events")
	// The window only runs once polling has started.
	`TBGC_ASSERT_NEVER(a_window_needs_poll, window_armed_q && !poll_running_q, "window armed without poll")
	// An expiring window disarms.
	`TBGC_ASSERT(a_window_disarms, (accept && win_fire) |=> !window_armed_q, "window still armed after expiry")

endmodule

`default_nettype wire

[dv/three_button_gesture_classifier_checker.sv]
`timescale 1ns / 100ps

// Watches the tick, event and register channels of the gesture classifier.
// Every accepted tick is run through a cycle-free model of the classifier and
// the events it should cause are queued; every accepted event is compared
// against the oldest queued one.
module three_button_gesture_classifier_checker
	import tbgc_pkg::*;
#(
	parameter int COUNT_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [7:0]       m_tdata,
	input  logic             m_tlast,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	// One gesture event as it leaves the block.
	typedef struct packed {
		logic [BTN_W-1:0]  button;
		logic [KIND_W-1:0] kind;
		logic              last;
	} gesture_evt_t;

	// Classifier state as the model sees it.
	logic [COUNT_BITS-1:0] hold_len [NUM_LANES];
	logic [TALLY_W-1:0]    tally    [NUM_LANES];
	logic                  long_on  [NUM_LANES];
	logic [CFG_W-1:0]      win_left;
	logic                  win_armed;
	logic                  polling;

	// Register copies.
	logic [CFG_W-1:0] long_ticks;
	logic [CFG_W-1:0] short_ticks;
	logic [CFG_W-1:0] win_ticks;

	gesture_evt_t tick_events[$];
	gesture_evt_t due_events[$];
	int           fails = 0;
	int           seen = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
		checked    = 0;
	end

	task automatic log_failure(input string what);
		fails++;
		if (fails <= 10)
			$display("[%0t] gesture check: %s", $realtime, what);
	endtask

	// One poll tick of a held button: count up, fire a long event at the period.
	task automatic count_hold(input int b);
		if (hold_len[b] != '1)
			hold_len[b]++;
		if (hold_len[b] >= long_ticks) begin
			hold_len[b] -= long_ticks;
			tick_events.push_back('{BTN_W'(b),
				long_on[b] ? KIND_LONG_CONT : KIND_LONG_START, 1'b0});
			long_on[b] = 1'b1;
			tally[b]   = '0;
		end
	endtask

	// Release of all buttons: end a long hold, or report a late single.
	task automatic check_release(input int b);
		if (long_on[b])
			long_on[b] = 1'b0;
		else if (hold_len[b] >= short_ticks)
			tick_events.push_back('{BTN_W'(b), KIND_SINGLE, 1'b0});
	endtask

	// Work out the events of one tick and queue them behind the earlier ones.
	task automatic classify_tick(input logic [7:0] d);
		logic       h1, h2, h3;
		logic [1:0] push;
		int         b;
		h1   = d[0];
		h2   = d[1];
		h3   = d[2];
		push = d[4:3];
		tick_events.delete();

		// Push edge first.
		if (push != 2'd0) begin
			b = int'(push) - 1;
			if (tally[b] != '1)
				tally[b]++;
			win_left  = win_ticks;
			win_armed = 1'b1;
			polling   = 1'b1;
		end

		// Hold poll, with the one-and-two combo ahead of the single-button priority.
		if (polling) begin
			if (h1 && h2) begin
				count_hold(0);
				count_hold(1);
				hold_len[2] = '0;
			end else if (h2) begin
				count_hold(1);
				hold_len[0] = '0;
				hold_len[2] = '0;
			end else if (h1) begin
				count_hold(0);
				hold_len[1] = '0;
				hold_len[2] = '0;
			end else if (h3) begin
				count_hold(2);
				hold_len[0] = '0;
				hold_len[1] = '0;
			end else begin
				check_release(1);
				check_release(0);
				check_release(2);
				for (int i = 0; i < NUM_LANES; i++)
					hold_len[i] = '0;
			end
		end

		// Multi-press window last.
		if (win_armed) begin
			if (win_left != '0) begin
				win_left--;
			end else begin
				win_armed = 1'b0;
				for (int i = 0; i < NUM_LANES; i++) begin
					if (!long_on[i] && (32'(hold_len[i]) + 32'd1) < 32'(short_ticks)) begin
						if (tally[i] >= 8'd1 && tally[i] <= 8'd3)
							tick_events.push_back('{BTN_W'(i),
								KIND_SINGLE + KIND_W'(tally[i] - 8'd1), 1'b0});
						tally[i] = '0;
					end
				end
			end
		end

		if (tick_events.size() != 0)
			tick_events[tick_events.size() - 1].last = 1'b1;
		foreach (tick_events[i])
			due_events.push_back(tick_events[i]);
	endtask

	// Channel monitor: register writes, then ticks, then events.
	always @(posedge clk or negedge arst_n) begin
		gesture_evt_t got;
		gesture_evt_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				hold_len[i] = '0;
				tally[i]    = '0;
				long_on[i]  = 1'b0;
			end
			win_left    = '0;
			win_armed   = 1'b0;
			polling     = 1'b0;
			long_ticks  = LONG_HOLD_RST;
			short_ticks = SHORT_HOLD_RST;
			win_ticks   = WINDOW_RST;
			due_events.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LONG_HOLD:  long_ticks  = cfg_data;
					REG_SHORT_HOLD: short_ticks = cfg_data;
					REG_WINDOW:     win_ticks   = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				classify_tick(s_tdata);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[1:0], m_tdata[4:2], m_tlast};
				seen++;
				if (due_events.size() == 0) begin
					log_failure($sformatf("event %0d with nothing expected: button %0d kind %0d last %0d",
						seen, got.button, got.kind, got.last));
				end else begin
					want = due_events.pop_front();
					if (got != want)
						log_failure($sformatf({"event %0d: expected button %0d kind %0d last %0d,",
							" got button %0d kind %0d last %0d"}, seen, want.button, want.kind,
							want.last, got.button, got.kind, got.last));
				end
			end
			pending    <= due_events.size();
			fail_count <= fails;
			checked    <= seen;
		end
	end

endmodule

[dv/three_button_gesture_classifier_top_test.sv]
`timescale 1ns / 100ps

module three_button_gesture_classifier_top_test;
	import tbgc_pkg::*;

	localparam int         TB_COUNT_BITS = 12;
	localparam int         DRAIN_CYCLES  = 8;
	localparam int         STALL_LIMIT   = 2000;
	localparam logic [1:0] PUSH_NONE     = 2'd0;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = REG_LONG_HOLD;
	logic [CFG_W-1:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int checked;
	int tx_idle_pct   = 38;
	int rx_idle_pct   = 50;
	int ticks_sent    = 0;
	int settings_used = 1;
	int quiet_cycles  = 0;
	int cur_long      = LONG_HOLD_RST;
	int cur_win       = WINDOW_RST;

	always #5 clk = ~clk;

	three_button_gesture_classifier_top #(
		.COUNT_BITS(TB_COUNT_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	three_button_gesture_classifier_checker #(
		.COUNT_BITS(TB_COUNT_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// Event side back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: no channel activity for %0d cycles.", STALL_LIMIT);
			$display("three_button_gesture_classifier_top_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] tick_bits(input logic [2:0] held, input logic [1:0] push);
		return {3'b000, push, held};
	endfunction

	// Offer one tick after a random gap and wait until it is taken.
	task automatic send_tick(input logic [7:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Let every predicted event come out, then give a silent tick time to finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_config(input int l, input int s, input int w);
		settle();
		write_reg(REG_LONG_HOLD, l);
		write_reg(REG_SHORT_HOLD, s);
		write_reg(REG_WINDOW, w);
		cfg_valid <= 1'b0;
		cur_long  = l;
		cur_win   = w;
		settings_used++;
	endtask

	// A press sequence on one button (sometimes the one-and-two combo) with
	// random hold lengths, followed by enough quiet to let the window run out.
	task automatic play_gesture();
		int         lane;
		int         presses;
		int         hold_ticks;
		int         lim;
		logic [2:0] held;
		lane    = $urandom_range(2);
		presses = $urandom_range(1, 4);
		lim     = (cur_long < 10) ? 2 * cur_long + 2 : 12;
		repeat (presses) begin
			held = 3'b001 << lane;
			if (lane != 2 && $urandom_range(7) == 0)
				held = 3'b011;
			send_tick(tick_bits(held, 2'(lane + 1)));
			hold_ticks = $urandom_range(0, lim);
			repeat (hold_ticks)
				send_tick(tick_bits(held, PUSH_NONE));
			repeat ($urandom_range(1, 2))
				send_tick(tick_bits(3'b000, PUSH_NONE));
		end
		repeat ((cur_win < 10 ? cur_win : 10) + $urandom_range(0, 2))
			send_tick(tick_bits(3'b000, PUSH_NONE));
	endtask

	task automatic play_noise();
		repeat ($urandom_range(1, 4))
			send_tick(tick_bits(3'($urandom), 2'($urandom)));
	endtask

	task automatic run_setting(input int l, input int s, input int w, input int n_ticks);
		int first;
		apply_config(l, s, w);
		first = ticks_sent;
		while (ticks_sent - first < n_ticks) begin
			if ($urandom_range(3) == 0)
				play_noise();
			else
				play_gesture();
		end
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// Register values after reset: poll stays off until the first push.
		send_tick(tick_bits(3'b111, PUSH_NONE));
		send_tick(tick_bits(3'b000, 2'd1));

		// Short periods: long start and continue, silent window, single, double, combo.
		apply_config(2, 2, 1);
		send_tick(tick_bits(3'b001, 2'd1));
		send_tick(tick_bits(3'b001, PUSH_NONE));
		send_tick(tick_bits(3'b001, PUSH_NONE));
		send_tick(tick_bits(3'b001, PUSH_NONE));
		send_tick(tick_bits(3'b000, PUSH_NONE));
		send_tick(tick_bits(3'b010, 2'd2));
		send_tick(tick_bits(3'b000, PUSH_NONE));
		send_tick(tick_bits(3'b000, 2'd2));
		send_tick(tick_bits(3'b000, 2'd2));
		send_tick(tick_bits(3'b000, PUSH_NONE));
		send_tick(tick_bits(3'b011, 2'd3));
		send_tick(tick_bits(3'b011, PUSH_NONE));
		send_tick(tick_bits(3'b100, PUSH_NONE));
		send_tick(tick_bits(3'b110, PUSH_NONE));
		send_tick(tick_bits(3'b000, PUSH_NONE));

		// All registers zero: long event on every held tick, window expires at once,
		// every release that does not end a long press reports a single.
		apply_config(0, 0, 0);
		send_tick(tick_bits(3'b001, 2'd1));
		send_tick(tick_bits(3'b000, PUSH_NONE));
		send_tick(tick_bits(3'b000, 2'd3));

		// All registers at their maximum.
		apply_config(4095, 4095, 4095);
		send_tick(tick_bits(3'b111, 2'd2));
		send_tick(tick_bits(3'b000, PUSH_NONE));

		// Push burst past the tally ceiling, then let the window expire.
		apply_config(50, 3, 8);
		repeat (257)
			send_tick(tick_bits(3'b000, 2'd1));
		repeat (10)
			send_tick(tick_bits(3'b000, PUSH_NONE));

		run_setting(6, 3, 4, 12);
		run_setting(1, 1, 1, 12);

		tx_idle_pct = 50;
		rx_idle_pct = 38;
		run_setting(4, 2, 0, 12);
		run_setting(0, 0, 2, 12);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_setting(4095, 4095, 3, 12);
		run_setting(8, 5, 6, 12);

		settle();
		$display("Sent %0d ticks under %0d register settings, three idle patterns.",
			ticks_sent, settings_used);
		$display("Compared %0d gesture events.", checked);
		if (fail_count == 0) begin
			$display("three_button_gesture_classifier_top_test: done, clean");
		end else begin
			$display("%0d failures.", fail_count);
			$display("three_button_gesture_classifier_top_test: done, errors");
		end
		$finish;
	end

endmodule
